@@ rtl/afm_pkg.sv @@
// ----------------------------------------------------------------------------
// afm_pkg: shared definitions for the averaging frequency meter
// Field widths, command codes, divider sizing and the control and status
// structs that pass between the top level and its submodules.
// ----------------------------------------------------------------------------
package afm_pkg;

  localparam int TIMER_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int CLK_W      = 28;
  localparam int SUM_W      = 48;
  localparam int EDGE_W     = 32;
  localparam int FREQ_W     = 36;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(120000000);

  // Command codes of an input item.
  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // The shared divider is as wide as the widest operand.
  localparam int DIV_W  = SUM_W;
  localparam int ITER_W = $clog2(DIV_W + 1);
  // Dividend of the frequency division: the clock rate with fraction bits.
  localparam int FDVD_W = CLK_W + FRAC_BITS;

  localparam logic [ITER_W-1:0] MEAN_ITERS = ITER_W'(SUM_W);
  localparam logic [ITER_W-1:0] FREQ_ITERS = ITER_W'(FDVD_W);

  typedef struct packed {
    logic                  edge_en;
    logic                  clear;
    logic [TIMER_BITS-1:0] now;
  } acc_ctl_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_sts_t;

endpackage

@@ rtl/afm_in_if.sv @@
// ----------------------------------------------------------------------------
// afm_in_if: input channel of the averaging frequency meter
// Valid/ready handshake carrying a command and a captured timer value.
// ----------------------------------------------------------------------------
interface afm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [afm_pkg::TIMER_BITS-1:0]  capture_time;

  modport source (output valid, output cmd, output capture_time, input ready);
  modport sink   (input valid, input cmd, input capture_time, output ready);
endinterface

@@ rtl/afm_out_if.sv @@
// ----------------------------------------------------------------------------
// afm_out_if: result channel of the averaging frequency meter
// Valid/ready handshake carrying the measured frequency and a no-data flag.
// ----------------------------------------------------------------------------
interface afm_out_if;
  logic                        valid;
  logic                        ready;
  logic [afm_pkg::FREQ_W-1:0]  frequency_q8;
  logic                        no_data;

  modport source (output valid, output frequency_q8, output no_data, input ready);
  modport sink   (input valid, input frequency_q8, input no_data, output ready);
endinterface

@@ rtl/afm_accum.sv @@
// ----------------------------------------------------------------------------
// afm_accum: period accumulator
// Forms the wrapped period between captures and keeps a saturating sum of
// periods and a saturating count of edges.
// ----------------------------------------------------------------------------
module afm_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  afm_pkg::acc_ctl_t            ctl,
  output logic [afm_pkg::SUM_W-1:0]    sum,
  output logic [afm_pkg::EDGE_W-1:0]   count
);

  logic [afm_pkg::TIMER_BITS-1:0] last_r;
  logic [afm_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [afm_pkg::EDGE_W-1:0]     cnt_r, cnt_nxt;
  logic [afm_pkg::TIMER_BITS-1:0] period;
  logic [afm_pkg::SUM_W:0]        sum_ext;

  // The period is always below 2^TIMER_BITS, so a carry out is the only overflow.
  assign period  = ctl.now - last_r;
  assign sum_ext = {1'b0, sum_r} + (afm_pkg::SUM_W + 1)'(period);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (ctl.edge_en) begin
      sum_nxt = sum_ext[afm_pkg::SUM_W] ? '1 : sum_ext[afm_pkg::SUM_W-1:0];
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      if (ctl.edge_en) begin
        last_r <= ctl.now;
      end
    end
  end

  assign sum   = sum_r;
  assign count = cnt_r;

endmodule

@@ rtl/afm_div.sv @@
// ----------------------------------------------------------------------------
// afm_div: bit-serial restoring divider
// The dividend shifts out one bit per cycle into the partial remainder and
// one quotient bit shifts in per cycle, for a programmable number of steps.
// ----------------------------------------------------------------------------
module afm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  afm_pkg::div_ctl_t  ctl,
  output afm_pkg::div_sts_t  sts
);

  logic                             busy_r;
  logic                             done_r;
  logic [afm_pkg::ITER_W-1:0]       cnt_r;
  logic [afm_pkg::DIV_W-1:0]        dvd_r;
  logic [afm_pkg::DIV_W-1:0]        dvs_r;
  logic [afm_pkg::DIV_W-1:0]        rem_r;
  logic [afm_pkg::DIV_W-1:0]        quo_r;
  logic [afm_pkg::DIV_W:0]          rem_shift;
  logic [afm_pkg::DIV_W+1:0]        diff;
  logic                             fits;

  assign rem_shift = {rem_r, dvd_r[afm_pkg::DIV_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs_r};
  assign fits      = !diff[afm_pkg::DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.iters;
        dvd_r  <= ctl.dividend;
        dvs_r  <= ctl.divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[afm_pkg::DIV_W-2:0], 1'b0};
        quo_r <= {quo_r[afm_pkg::DIV_W-2:0], fits};
        rem_r <= fits ? diff[afm_pkg::DIV_W-1:0] : rem_shift[afm_pkg::DIV_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == afm_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

@@ rtl/averaging_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// averaging_frequency_meter: reciprocal frequency counter with averaging
// Accumulates capture periods and, on a report, returns the clock rate over
// the mean period as unsigned fixed point with eight fraction bits.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  in_if     in         valid/ready      cmd, capture_time[23:0]
//  out_if    out        valid/ready      frequency_q8[35:0], no_data
//  cfg       in         cfg_we           cfg_wdata[27:0] (clock rate in Hz)
//
//  A capture edge is taken only in ST_IDLE. A report with edges uses the one
//  bit-serial divider: 48 steps for the mean period and, unless the mean is
//  zero, 36 for the frequency. A report with no edges skips the divider.
//  Reset clears the accumulators, the last capture and the output valid flag.
//  The result register lets edges be taken while a result waits on out_if.
// ----------------------------------------------------------------------------
module averaging_frequency_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  afm_in_if.sink                        in_if,
  afm_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [afm_pkg::CLK_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_DIV_FREQ,
    ST_DELIVER
  } state_t;

  state_t                          state_r, state_nxt;
  logic [afm_pkg::CLK_W-1:0]       clk_hz_r;
  logic [afm_pkg::FREQ_W-1:0]      res_freq_r, res_freq_nxt;
  logic                            res_flag_r, res_flag_nxt;
  logic                            out_valid_r;
  logic [afm_pkg::FREQ_W-1:0]      out_freq_r;
  logic                            out_flag_r;

  afm_pkg::acc_ctl_t               acc_ctl;
  afm_pkg::div_ctl_t               div_ctl;
  afm_pkg::div_sts_t               div_sts;
  logic [afm_pkg::SUM_W-1:0]       acc_sum;
  logic [afm_pkg::EDGE_W-1:0]      acc_count;

  logic                            in_acc;
  logic                            slot_free;
  logic                            load_out;
  logic                            quo_sat;

  afm_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .sum   (acc_sum),
    .count (acc_count)
  );

  afm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_r || out_if.ready;
  assign load_out    = (state_r == ST_DELIVER) && slot_free;
  assign quo_sat     = |div_sts.quotient[afm_pkg::DIV_W-1:afm_pkg::FREQ_W];

  assign acc_ctl.edge_en = in_acc && (in_if.cmd == afm_pkg::CMD_EDGE);
  assign acc_ctl.clear   = in_acc && (in_if.cmd == afm_pkg::CMD_REPORT);
  assign acc_ctl.now     = in_if.capture_time;

  always_comb begin
    state_nxt        = state_r;
    res_freq_nxt     = res_freq_r;
    res_flag_nxt     = res_flag_r;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = acc_sum;
    div_ctl.divisor  = afm_pkg::DIV_W'(acc_count);
    div_ctl.iters    = afm_pkg::MEAN_ITERS;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_ctl.clear) begin
          if (acc_count == '0) begin
            res_freq_nxt = '0;
            res_flag_nxt = 1'b1;
            state_nxt    = ST_DELIVER;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt     = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        // The dividend sits left-aligned so the quotient fills the low bits.
        div_ctl.dividend = {clk_hz_r, {afm_pkg::FRAC_BITS{1'b0}},
                            {(afm_pkg::DIV_W - afm_pkg::FDVD_W){1'b0}}};
        div_ctl.divisor  = div_sts.quotient;
        div_ctl.iters    = afm_pkg::FREQ_ITERS;
        if (div_sts.done) begin
          if (div_sts.quotient == '0) begin
            res_freq_nxt = '0;
            res_flag_nxt = 1'b1;
            state_nxt    = ST_DELIVER;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt     = ST_DIV_FREQ;
          end
        end
      end
      ST_DIV_FREQ: begin
        if (div_sts.done) begin
          res_freq_nxt = quo_sat ? '1 : div_sts.quotient[afm_pkg::FREQ_W-1:0];
          res_flag_nxt = 1'b0;
          state_nxt    = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clk_hz_r    <= afm_pkg::CLK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      res_freq_r <= res_freq_nxt;
      res_flag_r <= res_flag_nxt;
      if (cfg_we) begin
        clk_hz_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_freq_r  <= res_freq_r;
        out_flag_r  <= res_flag_r;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.frequency_q8 = out_freq_r;
  assign out_if.no_data      = out_flag_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIV_MEAN || state_r == ST_DIV_FREQ))
    else $error("divider finished outside a divide state");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flag_r) |-> (out_freq_r == '0))
    else $error("no-data result carries a nonzero frequency");

  a_busy_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_sts.busy) |-> (state_r == ST_DIV_MEAN || state_r == ST_DIV_FREQ))
    else $error("divider running outside a divide state");

  a_report_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_ctl.clear |=> (state_r != ST_IDLE))
    else $error("report item did not start a result");

endmodule
